/* src/cts_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cts_pkg: shared types and constants of the cruise throttle stepper
// Field widths, register indexes, button codes, reset values and the
// constants of the speed conversion.
// ----------------------------------------------------------------------------
package cts_pkg;

	// Field widths
	localparam int SampleW = 10;
	localparam int BtnW    = 5;
	localparam int SpeedW  = 9;
	localparam int WidthW  = 12;
	localparam int StepW   = 4;
	localparam int DutyW   = 8;

	// Configuration port
	localparam int CfgIdxW  = 3;
	localparam int CfgDataW = 12;

	// Register indexes
	localparam logic [CfgIdxW-1:0] REG_THR_MIN    = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_THR_MAX    = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_THR_STEP   = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_THR_CENTER = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_THR_BRAKE  = 3'd4;

	// Register reset values
	localparam logic [WidthW-1:0] RstThrMin    = 12'd80;
	localparam logic [WidthW-1:0] RstThrMax    = 12'd260;
	localparam logic [StepW-1:0]  RstThrStep   = 4'd2;
	localparam logic [WidthW-1:0] RstThrCenter = 12'd188;
	localparam logic [WidthW-1:0] RstThrBrake  = 12'd60;

	// Loop state reset value of the throttle width
	localparam logic [WidthW-1:0] RstWidth = 12'd188;

	// Button snapshot codes (single buttons) and the brake bit
	localparam int                BtnCentreBit = 4;
	localparam logic [BtnW-1:0]   BTN_UP       = 5'b01000;
	localparam logic [BtnW-1:0]   BTN_DOWN     = 5'b00010;
	localparam logic [BtnW-1:0]   BTN_RIGHT    = 5'b00001;

	// Limits
	localparam logic [SpeedW-1:0] SpeedMax = 9'd511;
	localparam logic [WidthW-1:0] WidthMax = 12'd4095;

	// Speed conversion: floor((x + 277) * 50 / 213).
	// Division by 213 is a multiply by ceil(2^24 / 213) = 78767 and a shift;
	// exact for dividends below 108240. The factor 50 is folded in.
	localparam int SumW        = SampleW + 1;
	localparam int ConvShift   = 24;
	localparam int ConvMulW    = 22;
	localparam int ProdW       = SumW + ConvMulW;
	localparam logic [SumW-1:0]     SampleOffset = 11'd277;
	localparam logic [ConvMulW-1:0] ConvMul      = 22'd3938350; // 50 * 78767

	// Configuration register set
	typedef struct packed {
		logic [WidthW-1:0] thr_min;
		logic [WidthW-1:0] thr_max;
		logic [StepW-1:0]  thr_step;
		logic [WidthW-1:0] thr_center;
		logic [WidthW-1:0] thr_brake;
	} cts_cfg_t;

	// One result item
	typedef struct packed {
		logic [WidthW-1:0] pulse_width;
		logic              enabled;
		logic              at_speed;
		logic [SpeedW-1:0] target_speed;
		logic [SpeedW-1:0] measured_speed;
		logic [DutyW-1:0]  backlight_duty;
	} cts_result_t;

endpackage

/* src/cts_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cts_if: item channels of the cruise throttle stepper
// Valid/ready channels for control-pass requests and their results.
// ----------------------------------------------------------------------------

// Control-pass request channel
interface cts_req_if;
	logic                          valid;
	logic                          ready;
	logic [cts_pkg::SampleW-1:0]   speed_sample;
	logic                          button_event;
	logic [cts_pkg::BtnW-1:0]      buttons;

	modport source (output valid, speed_sample, button_event, buttons, input ready);
	modport sink   (input valid, speed_sample, button_event, buttons, output ready);
endinterface

// Result channel
interface cts_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [cts_pkg::WidthW-1:0]    pulse_width;
	logic                          enabled;
	logic                          at_speed;
	logic [cts_pkg::SpeedW-1:0]    target_speed;
	logic [cts_pkg::SpeedW-1:0]    measured_speed;
	logic [cts_pkg::DutyW-1:0]     backlight_duty;

	modport source (output valid, pulse_width, enabled, at_speed, target_speed,
		measured_speed, backlight_duty, input ready);
	modport sink   (input valid, pulse_width, enabled, at_speed, target_speed,
		measured_speed, backlight_duty, output ready);
endinterface

/* src/cruise_throttle_stepper.sv */
`timescale 1ns / 1ps
// Flow: the input register loads an item on acceptance, and the result register
//   loads its result when the item leaves the input register, unless rsp stalls.
// Throughput: one item per cycle unless rsp stalls; the loop state updates as each
//   item leaves the input register, so items may follow back to back.
// Reset: arst_n clears the loop state and loads the register defaults.
// ----------------------------------------------------------------------------
// cruise_throttle_stepper: cruise-control throttle loop
// One item is one control pass: speed conversion, buttons, throttle step.
// ----------------------------------------------------------------------------
module cruise_throttle_stepper (
	input  logic                          clk,
	input  logic                          arst_n,
	cts_req_if.sink                       req,
	cts_rsp_if.source                     rsp,
	input  logic                          cfg_we,
	input  logic [cts_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [cts_pkg::CfgDataW-1:0]  cfg_wdata
);

	cts_pkg::cts_cfg_t   cfg;
	cts_pkg::cts_result_t res, result_q;

	logic                          valid_s1;
	logic [cts_pkg::SampleW-1:0]   speed_sample_s1;
	logic                          button_event_s1;
	logic [cts_pkg::BtnW-1:0]      buttons_s1;
	logic                          rsp_valid_q;
	logic                          advance;
	logic [cts_pkg::SpeedW-1:0]    measured;

	// Item moves on when the result register is free or being emptied
	assign advance   = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			speed_sample_s1 <= req.speed_sample;
			button_event_s1 <= req.button_event;
			buttons_s1      <= req.buttons;
		end
	end

	cts_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	cts_speed_conv u_conv (
		.speed_sample   (speed_sample_s1),
		.measured_speed (measured)
	);

	cts_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.advance        (advance),
		.cfg            (cfg),
		.button_event   (button_event_s1),
		.buttons        (buttons_s1),
		.measured_speed (measured),
		.pulse_width    (res.pulse_width),
		.enabled        (res.enabled),
		.at_speed       (res.at_speed),
		.target_speed   (res.target_speed)
	);

	assign res.measured_speed = measured;
	assign res.backlight_duty = speed_sample_s1[cts_pkg::SampleW-1 -: cts_pkg::DutyW];

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			result_q <= res;
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.pulse_width    = result_q.pulse_width;
	assign rsp.enabled        = result_q.enabled;
	assign rsp.at_speed       = result_q.at_speed;
	assign rsp.target_speed   = result_q.target_speed;
	assign rsp.measured_speed = result_q.measured_speed;
	assign rsp.backlight_duty = result_q.backlight_duty;

endmodule

/* src/cts_cfg_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cts_cfg_regs: configuration register file
// Five write-only throttle registers; writes beyond the last index are dropped.
// ----------------------------------------------------------------------------
module cts_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [cts_pkg::CfgIdxW-1:0]    cfg_index,
	input  logic [cts_pkg::CfgDataW-1:0]   cfg_wdata,
	output cts_pkg::cts_cfg_t              cfg
);

	cts_pkg::cts_cfg_t cfg_q;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.thr_min    <= cts_pkg::RstThrMin;
			cfg_q.thr_max    <= cts_pkg::RstThrMax;
			cfg_q.thr_step   <= cts_pkg::RstThrStep;
			cfg_q.thr_center <= cts_pkg::RstThrCenter;
			cfg_q.thr_brake  <= cts_pkg::RstThrBrake;
		end else if (cfg_we) begin
			unique case (cfg_index)
				cts_pkg::REG_THR_MIN:    cfg_q.thr_min    <= cfg_wdata;
				cts_pkg::REG_THR_MAX:    cfg_q.thr_max    <= cfg_wdata;
				cts_pkg::REG_THR_STEP:   cfg_q.thr_step   <= cfg_wdata[cts_pkg::StepW-1:0];
				cts_pkg::REG_THR_CENTER: cfg_q.thr_center <= cfg_wdata;
				cts_pkg::REG_THR_BRAKE:  cfg_q.thr_brake  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* src/cts_speed_conv.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cts_speed_conv: raw sample to speed units
// floor((sample + 277) * 50 / 213) by one reciprocal multiply and a shift.
// ----------------------------------------------------------------------------
module cts_speed_conv (
	input  logic [cts_pkg::SampleW-1:0] speed_sample,
	output logic [cts_pkg::SpeedW-1:0]  measured_speed
);

	logic [cts_pkg::SumW-1:0]  sum;
	logic [cts_pkg::ProdW-1:0] prod;

	// Offset, then scale by 50/213 in fixed point
	assign sum  = {1'b0, speed_sample} + cts_pkg::SampleOffset;
	assign prod = cts_pkg::ProdW'(sum) * cts_pkg::ProdW'(cts_pkg::ConvMul);
	assign measured_speed = prod[cts_pkg::ConvShift +: cts_pkg::SpeedW];

endmodule

/* src/cts_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cts_ctrl: button handling and throttle stepping
// Holds the loop state and works out one control pass per advancing item.
// ----------------------------------------------------------------------------
module cts_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          advance,
	input  cts_pkg::cts_cfg_t             cfg,
	input  logic                          button_event,
	input  logic [cts_pkg::BtnW-1:0]      buttons,
	input  logic [cts_pkg::SpeedW-1:0]    measured_speed,
	output logic [cts_pkg::WidthW-1:0]    pulse_width,
	output logic                          enabled,
	output logic                          at_speed,
	output logic [cts_pkg::SpeedW-1:0]    target_speed
);

	logic [cts_pkg::SpeedW-1:0] set_point_q;
	logic [cts_pkg::WidthW-1:0] width_q;
	logic                       active_q;
	logic                       captured_q;
	logic                       lamp_q;

	logic [cts_pkg::SpeedW-1:0] sp_b, sp_c;
	logic [cts_pkg::WidthW-1:0] w_b, w_c, w_n;
	logic                       act_b, lamp_b, lamp_n, cap_n;
	logic [cts_pkg::WidthW:0]   w_up;

	// Buttons act first
	always_comb begin
		sp_b   = set_point_q;
		w_b    = width_q;
		act_b  = active_q;
		lamp_b = lamp_q;
		if (button_event) begin
			if (buttons[cts_pkg::BtnCentreBit]) begin
				// brake: other buttons ignored
				w_b    = cfg.thr_brake;
				act_b  = 1'b0;
				lamp_b = 1'b0;
			end else begin
				case (buttons)
					cts_pkg::BTN_UP: begin
						if (set_point_q != cts_pkg::SpeedMax)
							sp_b = set_point_q + 1'b1;
					end
					cts_pkg::BTN_DOWN: begin
						if (set_point_q != '0)
							sp_b = set_point_q - 1'b1;
					end
					cts_pkg::BTN_RIGHT: begin
						act_b  = !active_q;
						lamp_b = active_q ? 1'b0 : lamp_q;
					end
					default: ;
				endcase
			end
		end
	end

	// Loop step: capture on first enable, then one step towards the set speed
	always_comb begin
		sp_c   = sp_b;
		w_c    = w_b;
		cap_n  = captured_q;
		lamp_n = lamp_b;
		w_n    = w_b;
		w_up   = '0;
		if (act_b) begin
			if (!captured_q) begin
				w_c   = cfg.thr_center;
				sp_c  = measured_speed;
				cap_n = 1'b1;
			end
			w_n  = w_c;
			w_up = {1'b0, w_c} + (cts_pkg::WidthW+1)'(cfg.thr_step);
			if (sp_c == measured_speed) begin
				lamp_n = 1'b1;
			end else if (sp_c < measured_speed) begin
				// too fast: close, floor at zero
				lamp_n = 1'b0;
				if (w_c > cfg.thr_min)
					w_n = (w_c > cts_pkg::WidthW'(cfg.thr_step)) ?
						w_c - cts_pkg::WidthW'(cfg.thr_step) : '0;
			end else begin
				// too slow: open, saturating
				lamp_n = 1'b0;
				if (w_c < cfg.thr_max)
					w_n = w_up[cts_pkg::WidthW] ? cts_pkg::WidthMax : w_up[cts_pkg::WidthW-1:0];
			end
		end
	end

	// Loop state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_point_q <= '0;
			width_q     <= cts_pkg::RstWidth;
			active_q    <= 1'b0;
			captured_q  <= 1'b0;
			lamp_q      <= 1'b0;
		end else if (advance) begin
			set_point_q <= sp_c;
			width_q     <= w_n;
			active_q    <= act_b;
			captured_q  <= cap_n;
			lamp_q      <= lamp_n;
		end
	end

	assign pulse_width  = w_n;
	assign enabled      = act_b;
	assign at_speed     = lamp_n;
	assign target_speed = sp_c;

	// Lamp only lit while the loop runs
	a_lamp_needs_active: assert property (@(posedge clk) disable iff (!arst_n)
		lamp_q |-> active_q)
		else $error("lamp lit with loop inactive");

	// A running loop has always captured its set speed
	a_active_captured: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> captured_q)
		else $error("loop active without capture");

	// Capture is kept until reset
	a_capture_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		captured_q |=> captured_q)
		else $error("capture flag cleared");

	// Brake stops the loop and puts out the lamp
	a_brake: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && button_event && buttons[cts_pkg::BtnCentreBit])
		|=> (!active_q && !lamp_q && width_q == cfg.thr_brake))
		else $error("brake did not act");

endmodule

/* bench/throttle_pass_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// throttle_pass_checker: result checker for the cruise throttle stepper
// Follows register writes and accepted control passes, predicts each result
// from its own copy of the loop state, and compares every result that leaves
// the block, field by field, against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module throttle_pass_checker
	import cts_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	cts_req_if                  req,
	cts_rsp_if                  rsp,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_wdata,
	output int                  errors,
	output int                  pending,
	output int                  checked,
	output int                  lamp_lit
);

	// Speed conversion: floor((sample + bias) * num / den)
	localparam int ConvBias = 277;
	localparam int ConvNum  = 50;
	localparam int ConvDen  = 213;

	typedef struct packed {
		logic [SpeedW-1:0] set_point;
		logic [WidthW-1:0] width;
		logic              active;
		logic              captured;
		logic              lamp;
	} loop_state_t;

	loop_state_t loop_st;
	cts_cfg_t    regs;
	cts_result_t awaited_passes[$];

	// One control pass: buttons first, then the throttle step
	function automatic cts_result_t control_pass(input logic [SampleW-1:0] sample,
		input logic ev, input logic [BtnW-1:0] btns);
		cts_result_t       r;
		logic [SpeedW-1:0] speed;
		logic [WidthW:0]   raised;
		speed = SpeedW'((int'(sample) + ConvBias) * ConvNum / ConvDen);
		if (ev) begin
			if (btns[BtnCentreBit]) begin
				// brake wins over anything else in the snapshot
				loop_st.width  = regs.thr_brake;
				loop_st.active = 1'b0;
				loop_st.lamp   = 1'b0;
			end else if (btns == BTN_UP) begin
				if (loop_st.set_point != SpeedMax)
					loop_st.set_point = loop_st.set_point + 1'b1;
			end else if (btns == BTN_DOWN) begin
				if (loop_st.set_point != '0)
					loop_st.set_point = loop_st.set_point - 1'b1;
			end else if (btns == BTN_RIGHT) begin
				loop_st.active = !loop_st.active;
				if (!loop_st.active)
					loop_st.lamp = 1'b0;
			end
		end
		if (loop_st.active) begin
			// capture happens once per reset only
			if (!loop_st.captured) begin
				loop_st.width     = regs.thr_center;
				loop_st.set_point = speed;
				loop_st.captured  = 1'b1;
			end
			if (loop_st.set_point == speed) begin
				loop_st.lamp = 1'b1;
			end else if (loop_st.set_point < speed) begin
				loop_st.lamp = 1'b0;
				if (loop_st.width > regs.thr_min)
					loop_st.width = (loop_st.width > WidthW'(regs.thr_step)) ?
						loop_st.width - WidthW'(regs.thr_step) : '0;
			end else begin
				loop_st.lamp = 1'b0;
				if (loop_st.width < regs.thr_max) begin
					raised = {1'b0, loop_st.width} + (WidthW+1)'(regs.thr_step);
					loop_st.width = (raised > {1'b0, WidthMax}) ? WidthMax : raised[WidthW-1:0];
				end
			end
		end
		r.pulse_width    = loop_st.width;
		r.enabled        = loop_st.active;
		r.at_speed       = loop_st.lamp;
		r.target_speed   = loop_st.set_point;
		r.measured_speed = speed;
		r.backlight_duty = sample[SampleW-1:2];
		return r;
	endfunction

	function automatic void check_field(input string name, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endfunction

	// Watch both channels and the register port at every rising edge
	always @(posedge clk or negedge arst_n) begin : watch
		cts_result_t want;
		cts_result_t got;
		if (!arst_n) begin
			regs = '{thr_min: RstThrMin, thr_max: RstThrMax, thr_step: RstThrStep,
				thr_center: RstThrCenter, thr_brake: RstThrBrake};
			loop_st = '{set_point: '0, width: RstWidth, active: 1'b0, captured: 1'b0,
				lamp: 1'b0};
			awaited_passes.delete();
			errors   = 0;
			pending  = 0;
			checked  = 0;
			lamp_lit = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_THR_MIN:    regs.thr_min    = cfg_wdata;
					REG_THR_MAX:    regs.thr_max    = cfg_wdata;
					REG_THR_STEP:   regs.thr_step   = cfg_wdata[StepW-1:0];
					REG_THR_CENTER: regs.thr_center = cfg_wdata;
					REG_THR_BRAKE:  regs.thr_brake  = cfg_wdata;
					default: ;
				endcase
			end
			if (rsp.valid && rsp.ready) begin
				if (awaited_passes.size() == 0) begin
					$error("result item with no control pass awaiting it");
					errors++;
				end else begin
					want = awaited_passes.pop_front();
					got  = '{pulse_width: rsp.pulse_width, enabled: rsp.enabled,
						at_speed: rsp.at_speed, target_speed: rsp.target_speed,
						measured_speed: rsp.measured_speed,
						backlight_duty: rsp.backlight_duty};
					check_field("pulse_width", want.pulse_width, got.pulse_width);
					check_field("enabled", want.enabled, got.enabled);
					check_field("at_speed", want.at_speed, got.at_speed);
					check_field("target_speed", want.target_speed, got.target_speed);
					check_field("measured_speed", want.measured_speed, got.measured_speed);
					check_field("backlight_duty", want.backlight_duty, got.backlight_duty);
					checked++;
					if (want.at_speed)
						lamp_lit++;
				end
			end
			if (req.valid && req.ready)
				awaited_passes.push_back(control_pass(req.speed_sample, req.button_event,
					req.buttons));
			pending = awaited_passes.size();
		end
	end

endmodule

/* bench/cruise_throttle_stepper_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cruise_throttle_stepper_tb: testbench of the cruise throttle stepper
// Directed passes over buttons, capture, brake and step limits, then random
// cruising, button bursts, brake-and-resume and noise under six register
// settings, with random stalls on both channels; a checker compares results.
// ----------------------------------------------------------------------------
module cruise_throttle_stepper_tb;
	import cts_pkg::*;

	localparam int ResetCycles = 7;
	localparam int CycleLimit  = 200000;
	localparam int DrainCycles = 8;
	localparam int ItemsTarget = 1230;
	localparam int IdlePct     = 16;
	localparam int CalmFrom    = 600;
	localparam int CalmTo      = 780;

	localparam logic [BtnW-1:0]    BtnCentre  = BtnW'(1) << BtnCentreBit;
	localparam logic [BtnW-1:0]    BtnLeft    = 5'b00100;
	localparam logic [BtnW-1:0]    SingleKeys [4] = '{BTN_UP, BTN_DOWN, BTN_RIGHT, BtnLeft};
	localparam logic [SampleW-1:0] SampleLow  = '0;
	localparam logic [SampleW-1:0] SampleHigh = '1;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_we;
	logic [CfgIdxW-1:0]  cfg_index;
	logic [CfgDataW-1:0] cfg_wdata;
	logic                calm;
	logic [SampleW-1:0]  walk;
	int                  errors;
	int                  pending;
	int                  checked;
	int                  lamp_lit;
	int                  sent = 0;
	int                  cycles = 0;

	cts_req_if req ();
	cts_rsp_if rsp ();

	cruise_throttle_stepper dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	throttle_pass_checker checker_i (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.errors    (errors),
		.pending   (pending),
		.checked   (checked),
		.lamp_lit  (lamp_lit)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// no idling on either side inside this window of items
	assign calm = (sent >= CalmFrom) && (sent < CalmTo);

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CycleLimit) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Result side: random stalls
	initial begin
		rsp.ready = 1'b0;
		forever begin
			@(negedge clk);
			rsp.ready <= calm || ($urandom_range(99) >= IdlePct);
		end
	end

	// Speed sample that wanders a little from pass to pass
	function automatic logic [SampleW-1:0] drifted(input logic [SampleW-1:0] s);
		int v;
		v = int'(s) + int'($urandom_range(6)) - 3;
		if (v < 0)
			v = 0;
		if (v > int'(SampleHigh))
			v = int'(SampleHigh);
		return SampleW'(v);
	endfunction

	// Offer one item, idling first at random; returns at the falling edge
	// after acceptance with valid still high
	task automatic send_pass(input logic [SampleW-1:0] sample, input logic ev,
		input logic [BtnW-1:0] btns);
		while (!calm && ($urandom_range(99) < IdlePct)) begin
			req.valid <= 1'b0;
			@(negedge clk);
		end
		req.valid        <= 1'b1;
		req.speed_sample <= sample;
		req.button_event <= ev;
		req.buttons      <= btns;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		@(negedge clk);
		sent++;
	endtask

	task automatic press(input logic [SampleW-1:0] sample, input logic [BtnW-1:0] btns);
		send_pass(sample, 1'b1, btns);
	endtask

	// No snapshot: the button lines carry junk that must be ignored
	task automatic coast(input logic [SampleW-1:0] sample);
		send_pass(sample, 1'b0, BtnW'($urandom));
	endtask

	// Register writes only once the block has drained
	task automatic load_regs(input cts_cfg_t c);
		logic [CfgIdxW-1:0]  idx [5];
		logic [CfgDataW-1:0] val [5];
		idx = '{REG_THR_MIN, REG_THR_MAX, REG_THR_STEP, REG_THR_CENTER, REG_THR_BRAKE};
		val = '{c.thr_min, c.thr_max, CfgDataW'(c.thr_step), c.thr_center, c.thr_brake};
		req.valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (DrainCycles) @(negedge clk);
		for (int i = 0; i < 5; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= idx[i];
			cfg_wdata <= val[i];
			@(negedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	function automatic cts_cfg_t random_regs();
		cts_cfg_t c;
		c.thr_min    = WidthW'($urandom_range(2500));
		c.thr_max    = WidthW'($urandom_range(2500));
		c.thr_step   = StepW'($urandom_range(15, 1));
		c.thr_center = WidthW'($urandom_range(2500));
		c.thr_brake  = WidthW'($urandom_range(2500));
		return c;
	endfunction

	// Mixed random traffic: cruising, bursts, brake and resume, noise
	task automatic random_stretch(input int n);
		int              stop;
		int              kind;
		logic [BtnW-1:0] key;
		stop = sent + n;
		while (sent < stop) begin
			kind = $urandom_range(99);
			if (kind < 60) begin
				repeat ($urandom_range(40, 10)) begin
					walk = drifted(walk);
					if ($urandom_range(99) < 12)
						press(walk, SingleKeys[$urandom_range(3)]);
					else
						coast(walk);
				end
			end else if (kind < 75) begin
				key = $urandom_range(1) ? BTN_UP : BTN_DOWN;
				repeat ($urandom_range(20, 3)) begin
					walk = drifted(walk);
					press(walk, key);
				end
			end else if (kind < 85) begin
				press(walk, BtnCentre | BtnW'($urandom_range(15)));
				repeat ($urandom_range(4)) begin
					walk = drifted(walk);
					coast(walk);
				end
				press(walk, BTN_RIGHT);
			end else begin
				repeat ($urandom_range(15, 5))
					send_pass(SampleW'($urandom), 1'($urandom), BtnW'($urandom));
			end
		end
	endtask

	initial begin
		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_index        = '0;
		cfg_wdata        = '0;
		req.valid        = 1'b0;
		req.speed_sample = '0;
		req.button_event = 1'b0;
		req.buttons      = '0;
		walk             = SampleHigh;
		repeat (ResetCycles) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: reset register values, loop off
		coast(SampleLow);
		press(SampleHigh, '0);
		press(SampleHigh, BTN_DOWN);                 // set speed held at zero
		press(SampleHigh, BTN_UP);
		press(SampleHigh, BtnLeft);
		press(SampleHigh, BTN_UP | BTN_DOWN);        // two buttons: no effect
		send_pass(SampleHigh, 1'b0, BTN_UP);         // no snapshot: ignored
		press(SampleHigh, BTN_RIGHT);                // first enable captures
		coast(SampleHigh);
		coast(SampleLow);                            // too slow: opens
		press(SampleHigh, BTN_UP);
		press(SampleHigh, BTN_DOWN);
		press(SampleHigh, BTN_DOWN);                 // too fast: closes
		press(SampleHigh, BTN_RIGHT);                // off, lamp off
		press(SampleHigh, BTN_RIGHT);                // back on, no new capture
		press(SampleHigh, BtnCentre | BTN_UP | BtnLeft | BTN_DOWN | BTN_RIGHT);
		press(SampleHigh, BtnCentre);
		press(SampleHigh, BTN_RIGHT);                // brake width below min
		coast(SampleLow);
		press(SampleHigh, BtnCentre | BTN_RIGHT);
		press(SampleHigh, BTN_RIGHT);
		press(SampleHigh, BTN_UP);

		// Wide limits: climb to the set speed ceiling, then saturate the width
		load_regs('{thr_min: 12'd0, thr_max: 12'd4095, thr_step: 4'd15,
			thr_center: 12'd4095, thr_brake: 12'd4090});
		repeat (215) begin
			walk = drifted(walk);
			press(walk, BTN_UP);
		end
		press(walk, BtnCentre);
		press(walk, BTN_RIGHT);
		repeat (3) coast(walk);

		// Closed limits and zero step
		load_regs('{thr_min: 12'd4095, thr_max: 12'd0, thr_step: 4'd0,
			thr_center: 12'd0, thr_brake: 12'd0});
		random_stretch(150);

		// Small brake width: the closing step floors at zero
		load_regs('{thr_min: 12'd0, thr_max: 12'd2500, thr_step: 4'd15,
			thr_center: 12'd2500, thr_brake: 12'd5});
		repeat (260) begin
			walk = drifted(walk);
			press(walk, BTN_DOWN);
		end
		press(SampleHigh, BtnCentre);
		press(SampleHigh, BTN_RIGHT);
		repeat (3) coast(SampleHigh);
		random_stretch(150);

		load_regs(random_regs());
		random_stretch(150);
		load_regs(random_regs());
		random_stretch(150);

		// Back to the reset values
		load_regs('{thr_min: RstThrMin, thr_max: RstThrMax, thr_step: RstThrStep,
			thr_center: RstThrCenter, thr_brake: RstThrBrake});
		random_stretch((ItemsTarget > sent + 50) ? ItemsTarget - sent : 50);

		// Drain
		req.valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (DrainCycles) @(negedge clk);

		$display("Sent %0d control passes under six register settings, %0d results checked.",
			sent, checked);
		$display("Lamp was lit on %0d of them.", lamp_lit);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

/* cruise_throttle_stepper.f */
src/cts_pkg.sv
src/cts_if.sv
src/cts_cfg_regs.sv
src/cts_speed_conv.sv
src/cts_ctrl.sv
src/cruise_throttle_stepper.sv
bench/throttle_pass_checker.sv
bench/cruise_throttle_stepper_tb.sv
